@@ hw/rtl/tcp_port_fixed_window_limiter_defines.svh @@
// ----------------------------------------------------------------------------
// tcp_port_fixed_window_limiter_defines
// Assertion macros for the TCP port fixed-window limiter.
// ----------------------------------------------------------------------------
`ifndef TCP_PORT_FIXED_WINDOW_LIMITER_DEFINES_SVH
`define TCP_PORT_FIXED_WINDOW_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TPFWL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPFWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPFWL_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPFWL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hw/rtl/tpfwl_pkg.sv @@
// ----------------------------------------------------------------------------
// tpfwl_pkg
// Types and constants shared by the TCP port fixed-window limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpfwl_pkg;

    localparam int CTR_W = 32;
    localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] RST_PORT_A   = 16'd8443;
    localparam logic [15:0] RST_PORT_B   = 16'd8090;
    localparam logic [31:0] RST_LIMIT_A  = 32'd20000;
    localparam logic [31:0] RST_LIMIT_B  = 32'd5000;
    localparam logic [31:0] RST_WINDOW   = 32'd1000000000;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    localparam logic [15:0] OFS_ETYPE_HI = 16'd12;
    localparam logic [15:0] OFS_ETYPE_LO = 16'd13;
    localparam logic [15:0] OFS_IHL      = 16'd14;
    localparam logic [15:0] OFS_PROTO    = 16'd23;
    localparam logic [6:0]  OFS_DPORT_BASE = 7'd16;
    localparam logic [16:0] MIN_LEN      = 17'd34;
    localparam logic [6:0]  HDR_LEN_BASE = 7'd34;

    typedef enum logic [2:0] {
        CFG_PORT_A = 3'd0,
        CFG_PORT_B = 3'd1,
        CFG_LIMIT_A = 3'd2,
        CFG_LIMIT_B = 3'd3,
        CFG_WINDOW = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_A = 2'd1,
        CLS_B = 2'd2
    } t_class;

    typedef struct packed {
        logic        valid;
        t_class      cls;
        logic [63:0] frame_time;
    } t_req;

    typedef struct packed {
        logic [31:0] packets;
        logic [31:0] drops;
        t_class      cls;
        logic        verdict;
    } t_result;

endpackage

@@ hw/rtl/tcp_port_fixed_window_limiter.sv @@
// TCP destination-port fixed-window limiter. Takes one frame byte per cycle while
// s_axis_tready is high, with no gaps required; each byte passes through the header
// parser, and a frame's last byte yields a verdict from the per-port window counters
// via parser and judge registers. The result stream has a four-entry queue, so
// s_axis_tready stays high while results wait, and drops only once four verdicts are
// queued or in flight. Config writes are taken in any cycle (o_cfg_ready tied high).
// ----------------------------------------------------------------------------
// tcp_port_fixed_window_limiter
// Top level: config registers, parser, window judge and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_port_fixed_window_limiter_defines.svh"

module tcp_port_fixed_window_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // frame byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [7:0] frame_byte, [71:8] arrival_ns
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] first_of_frame
    // verdict stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] class_drops, [63:32] class_packets
    output logic [2:0]  m_axis_tuser    // [0] verdict, [2:1] matched_class
);
    import tpfwl_pkg::*;

    logic [15:0] r_port_a;
    logic [15:0] r_port_b;
    logic [31:0] r_limit_a;
    logic [31:0] r_limit_b;
    logic [31:0] r_window;

    logic                  w_accept;
    t_req                  w_req;
    logic                  w_res_valid;
    t_result               w_res;
    t_result               w_head;
    logic [FIFO_CNT_W-1:0] w_count;
    logic [FIFO_CNT_W:0]   w_in_flight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a  <= RST_PORT_A;
            r_port_b  <= RST_PORT_B;
            r_limit_a <= RST_LIMIT_A;
            r_limit_b <= RST_LIMIT_B;
            r_window  <= RST_WINDOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PORT_A:  r_port_a  <= i_cfg_data[15:0];
                CFG_PORT_B:  r_port_b  <= i_cfg_data[15:0];
                CFG_LIMIT_A: r_limit_a <= i_cfg_data;
                CFG_LIMIT_B: r_limit_b <= i_cfg_data;
                CFG_WINDOW:  r_window  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign w_in_flight   = {1'b0, w_count} + {{FIFO_CNT_W{1'b0}}, w_req.valid} +
                           {{FIFO_CNT_W{1'b0}}, w_res_valid};
    assign s_axis_tready = (w_in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    tpfwl_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_byte       (s_axis_tdata[7:0]),
        .i_first      (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_arrival_ns (s_axis_tdata[71:8]),
        .i_port_a     (r_port_a),
        .i_port_b     (r_port_b),
        .o_req        (w_req)
    );

    tpfwl_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_limit_a   (r_limit_a),
        .i_limit_b   (r_limit_b),
        .i_window_ns (r_window),
        .o_valid     (w_res_valid),
        .o_result    (w_res)
    );

    tpfwl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_head),
        .o_count (w_count)
    );

    assign m_axis_tdata = {w_head.packets, w_head.drops};
    assign m_axis_tuser = {w_head.cls, w_head.verdict};

    `TPFWL_ASSERT(a_no_overflow, i_clk, i_rst_n, w_in_flight <= (FIFO_CNT_W + 1)'(FIFO_DEPTH), "result queue overflow")
    `TPFWL_ASSERT(a_req_only_on_last, i_clk, i_rst_n, (w_accept && !s_axis_tlast) |=> !w_req.valid, "request without frame end")
    `TPFWL_ASSERT(a_drop_has_class, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] != CLS_NONE), "drop on unmatched frame")
    `TPFWL_ASSERT(a_req_to_result, i_clk, i_rst_n, w_req.valid |=> w_res_valid, "request lost in judge")

endmodule

@@ hw/rtl/tpfwl_parser.sv @@
// ----------------------------------------------------------------------------
// tpfwl_parser
// Byte-wise header parser; issues one classification request per frame end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpfwl_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_first,
    input  logic               i_last,
    input  logic [63:0]        i_arrival_ns,
    input  logic [15:0]        i_port_a,
    input  logic [15:0]        i_port_b,
    output tpfwl_pkg::t_req    o_req
);
    import tpfwl_pkg::*;

    logic        r_open;
    logic [15:0] r_offset;
    logic [63:0] r_frame_time;
    logic [15:0] r_etype;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [15:0] r_dport;
    t_req        r_req;

    logic        w_start;
    logic [15:0] w_cur;
    logic [15:0] n_offset;
    logic [63:0] n_frame_time;
    logic [15:0] n_etype;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [15:0] n_dport;
    logic [3:0]  w_ihl_base;
    logic [6:0]  w_dp;
    logic [16:0] w_len;
    logic [16:0] w_hdr_len;
    logic        w_ok;
    t_req        n_req;

    always_comb begin
        w_start      = i_first || !r_open;
        w_cur        = w_start ? 16'd0 : r_offset;
        n_frame_time = w_start ? i_arrival_ns : r_frame_time;
        n_etype      = w_start ? 16'd0 : r_etype;
        w_ihl_base   = w_start ? 4'd0 : r_ihl;
        n_proto      = w_start ? 8'd0 : r_proto;
        n_dport      = w_start ? 16'd0 : r_dport;
        n_ihl        = w_ihl_base;
        w_dp         = OFS_DPORT_BASE + {1'b0, w_ihl_base, 2'b00};

        if (w_cur == OFS_ETYPE_HI) begin
            n_etype[15:8] = i_byte;
        end
        if (w_cur == OFS_ETYPE_LO) begin
            n_etype[7:0] = i_byte;
        end
        if (w_cur == OFS_IHL) begin
            n_ihl = i_byte[3:0];
        end
        if (w_cur == OFS_PROTO) begin
            n_proto = i_byte;
        end
        if (w_ihl_base >= IHL_MIN) begin
            if (w_cur == {9'd0, w_dp}) begin
                n_dport[15:8] = i_byte;
            end
            if (w_cur == {9'd0, w_dp} + 16'd1) begin
                n_dport[7:0] = i_byte;
            end
        end

        n_offset  = (w_cur == 16'hFFFF) ? w_cur : w_cur + 16'd1;
        w_len     = {1'b0, w_cur} + 17'd1;
        w_hdr_len = {10'd0, HDR_LEN_BASE + {1'b0, n_ihl, 2'b00}};
        w_ok      = (w_len >= MIN_LEN) && (n_etype == ETHERTYPE_IPV4) &&
                    (n_proto == PROTO_TCP) && (n_ihl >= IHL_MIN) && (w_len >= w_hdr_len);

        n_req.valid      = i_accept && i_last;
        n_req.frame_time = n_frame_time;
        if (!w_ok) begin
            n_req.cls = CLS_NONE;
        end else if (n_dport == i_port_a) begin
            n_req.cls = CLS_A;
        end else if (n_dport == i_port_b) begin
            n_req.cls = CLS_B;
        end else begin
            n_req.cls = CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_offset <= 16'd0;
            r_req    <= '0;
        end else begin
            r_req <= n_req;
            if (i_accept) begin
                r_open   <= !i_last;
                r_offset <= i_last ? 16'd0 : n_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_frame_time <= n_frame_time;
            r_etype      <= n_etype;
            r_ihl        <= n_ihl;
            r_proto      <= n_proto;
            r_dport      <= n_dport;
        end
    end

    assign o_req = r_req;

endmodule

@@ hw/rtl/tpfwl_judge.sv @@
// ----------------------------------------------------------------------------
// tpfwl_judge
// Per-port fixed-window counters; turns each request into a verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpfwl_judge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpfwl_pkg::t_req     i_req,
    input  logic [31:0]         i_limit_a,
    input  logic [31:0]         i_limit_b,
    input  logic [31:0]         i_window_ns,
    output logic                o_valid,
    output tpfwl_pkg::t_result  o_result
);
    import tpfwl_pkg::*;

    logic [63:0]      r_ws [2];
    logic [CTR_W-1:0] r_pk [2];
    logic [CTR_W-1:0] r_dc [2];
    logic             r_valid;
    t_result          r_result;

    logic             w_hit;
    logic             w_idx;
    logic [31:0]      w_lim;
    logic [63:0]      w_elapsed;
    logic             w_restart;
    logic [CTR_W-1:0] w_pk;
    logic             w_drop;
    logic [CTR_W-1:0] n_pk;
    logic [CTR_W-1:0] n_dc;
    t_result          n_result;

    always_comb begin
        w_hit     = i_req.valid && (i_req.cls != CLS_NONE);
        w_idx     = (i_req.cls == CLS_B);
        w_lim     = w_idx ? i_limit_b : i_limit_a;
        w_elapsed = i_req.frame_time - r_ws[w_idx];
        w_restart = (r_ws[w_idx] == 64'd0) || (w_elapsed >= {32'd0, i_window_ns});
        w_pk      = w_restart ? '0 : r_pk[w_idx];
        w_drop    = (32'(w_pk) >= w_lim) || (w_pk == CTR_MAX);
        n_pk      = w_drop ? w_pk : w_pk + CTR_W'(1);
        n_dc      = w_drop ? r_dc[w_idx] + CTR_W'(1) : r_dc[w_idx];

        if (i_req.cls == CLS_NONE) begin
            n_result.verdict = 1'b0;
            n_result.cls     = CLS_NONE;
            n_result.drops   = 32'd0;
            n_result.packets = 32'd0;
        end else begin
            n_result.verdict = w_drop;
            n_result.cls     = i_req.cls;
            n_result.drops   = 32'(n_dc);
            n_result.packets = 32'(n_pk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_ws[i] <= 64'd0;
                r_pk[i] <= '0;
                r_dc[i] <= '0;
            end
        end else begin
            r_valid <= i_req.valid;
            if (w_hit) begin
                if (w_restart) begin
                    r_ws[w_idx] <= i_req.frame_time;
                end
                r_pk[w_idx] <= n_pk;
                r_dc[w_idx] <= n_dc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hw/rtl/tpfwl_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tpfwl_out_fifo
// Small result queue that decouples the judge from the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpfwl_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  tpfwl_pkg::t_result                  i_data,
    input  logic                                i_pop,
    output logic                                o_valid,
    output tpfwl_pkg::t_result                  o_data,
    output logic [tpfwl_pkg::FIFO_CNT_W-1:0]    o_count
);
    import tpfwl_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic                  w_pop;
    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] n_rd_ptr;
    logic [FIFO_CNT_W-1:0] n_count;

    always_comb begin
        w_pop    = i_pop && (r_count != '0);
        n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + FIFO_PTR_W'(1);
        n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + FIFO_PTR_W'(1);
        n_count  = r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
